[design/sbms_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the multi-stack store.
package sbms_pkg;

    localparam int CAPACITY   = 32;
    localparam int NUM_STACKS = 3;

    localparam int DATA_W    = 32;
    localparam int ID_W      = 3;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int LEN_OUT_W = 6;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LIDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_READ_TOP,
        S_WAIT_TOP,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_DRAIN,
        S_WRITE_VAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_step;
        logic decide;
        logic top_read;
        logic top_capture;
        logic up_read;
        logic down_read;
        logic val_write;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic sum_last;
        logic bad;
        logic full;
        logic empty;
        logic up_more;
        logic up_last;
        logic down_more;
        logic down_last;
        logic out_free;
    } dp_stat_t;

endpackage

[design/shared_buffer_multi_stack_core.sv]
// Top level of the multi-stack shared store: controller plus datapath.
//
//   channel   signals                                            direction
//   request   in_valid/in_ready, req_type, stack_id, push_value   in
//   result    out_valid/out_ready, read_value, status,            out
//             stack_length, stack_empty
//
// One request at a time: accept, sum the stack lengths, decide, then shift the
// entries that must move (up to CAPACITY - 1), then read, drain or write as
// needed, and finish.
// Reset clears all stack lengths; the store needs no clearing.
// A held result does not block the next request; only the finish of that
// next request waits for the result register to be taken.
module shared_buffer_multi_stack_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sbms_pkg::OP_W-1:0]           req_type,
    input  logic [sbms_pkg::ID_W-1:0]           stack_id,
    input  logic signed [sbms_pkg::DATA_W-1:0]  push_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sbms_pkg::DATA_W-1:0]  read_value,
    output logic [sbms_pkg::ST_W-1:0]           status,
    output logic [sbms_pkg::LEN_OUT_W-1:0]      stack_length,
    output logic                                stack_empty
);
    import sbms_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sbms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .stack_id     (stack_id),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .stack_length (stack_length),
        .stack_empty  (stack_empty)
    );

endmodule

[design/sbms_ctrl.sv]
// Sequencing state machine for one request: sum lengths, read top, shift entries, write value, deliver result.
module sbms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sbms_pkg::dp_stat_t  stat,
    output sbms_pkg::ctrl_cmd_t cmd
);
    import sbms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (stat.sum_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (stat.bad || stat.op == OP_NOP)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.op == OP_PUSH)
                begin
                    priority if (stat.full)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (stat.up_more)
                    begin
                        state_next = S_SHIFT_UP;
                    end
                    else
                    begin
                        state_next = S_WRITE_VAL;
                    end
                end
                else
                begin
                    state_next = stat.empty ? S_FINISH : S_READ_TOP;
                end
            end
            S_READ_TOP:
            begin
                state_next = S_WAIT_TOP;
            end
            S_WAIT_TOP:
            begin
                if (stat.op == OP_POP && stat.down_more)
                begin
                    state_next = S_SHIFT_DOWN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP:
            begin
                if (stat.up_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_SHIFT_DOWN:
            begin
                if (stat.down_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (stat.op == OP_PUSH) ? S_WRITE_VAL : S_FINISH;
            end
            S_WRITE_VAL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_SUM:        cmd.sum_step    = 1'b1;
            S_DECIDE:     cmd.decide      = 1'b1;
            S_READ_TOP:   cmd.top_read    = 1'b1;
            S_WAIT_TOP:   cmd.top_capture = 1'b1;
            S_SHIFT_UP:   cmd.up_read     = 1'b1;
            S_SHIFT_DOWN: cmd.down_read   = 1'b1;
            S_DRAIN:      cmd             = '0;
            S_WRITE_VAL:  cmd.val_write   = 1'b1;
            S_FINISH:     cmd.finish      = stat.out_free;
            default:      cmd             = '0;
        endcase
    end

endmodule

[design/sbms_dp.sv]
// Datapath: shared store, stack lengths, shift pointers and result register.
module sbms_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbms_pkg::ctrl_cmd_t                 cmd,
    output sbms_pkg::dp_stat_t                  stat,
    input  logic [sbms_pkg::OP_W-1:0]           req_type,
    input  logic [sbms_pkg::ID_W-1:0]           stack_id,
    input  logic signed [sbms_pkg::DATA_W-1:0]  push_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sbms_pkg::DATA_W-1:0]  read_value,
    output logic [sbms_pkg::ST_W-1:0]           status,
    output logic [sbms_pkg::LEN_OUT_W-1:0]      stack_length,
    output logic                                stack_empty
);
    import sbms_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]  len_reg [NUM_STACKS];

    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [DATA_W-1:0] val_reg;

    logic [LIDX_W-1:0] sidx_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  top_end_reg;
    logic [CNT_W-1:0]  own_len_reg;
    logic [CNT_W-1:0]  ptr_reg;
    status_t           st_reg;
    logic [DATA_W-1:0] rd_reg;

    logic [DATA_W-1:0] rdata_reg;
    logic              wp_reg;
    logic [ADDR_W-1:0] wa_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    status_t                  status_reg;
    logic [LEN_OUT_W-1:0]     stack_length_reg;
    logic                     stack_empty_reg;

    logic [CNT_W-1:0]  sum_next;
    logic              bad;
    logic              full;
    logic              empty;
    logic              rd_en;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] wa_next;
    logic [CNT_W-1:0]  new_len;
    logic              len_we;

    assign sum_next = total_reg + len_reg[sidx_reg];
    assign bad      = !({1'b0, id_reg} < (ID_W + 1)'(NUM_STACKS));
    assign full     = total_reg >= CNT_W'(CAPACITY);
    assign empty    = own_len_reg == '0;

    always_comb
    begin
        stat           = '0;
        stat.op        = op_reg;
        stat.sum_last  = sidx_reg == LIDX_W'(NUM_STACKS - 1);
        stat.bad       = bad;
        stat.full      = full;
        stat.empty     = empty;
        stat.up_more   = total_reg > top_end_reg;
        stat.up_last   = ptr_reg == top_end_reg + CNT_W'(1);
        stat.down_more = ptr_reg < total_reg;
        stat.down_last = ptr_reg + CNT_W'(1) == total_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        rd_en   = cmd.top_read || cmd.up_read || cmd.down_read;
        ra      = ADDR_W'(ptr_reg);
        wa_next = ADDR_W'(ptr_reg - CNT_W'(1));
        priority if (cmd.top_read)
        begin
            ra = ADDR_W'(top_end_reg - CNT_W'(1));
        end
        else if (cmd.up_read)
        begin
            ra      = ADDR_W'(ptr_reg - CNT_W'(1));
            wa_next = ADDR_W'(ptr_reg);
        end
        else
        begin
            ra = ADDR_W'(ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wp_reg)
        begin
            mem[wa_reg] <= rdata_reg;
        end
        else if (cmd.val_write)
        begin
            mem[ADDR_W'(top_end_reg)] <= val_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
        end
        else
        begin
            wp_reg <= cmd.up_read || cmd.down_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.up_read || cmd.down_read)
        begin
            wa_reg <= wa_next;
        end
    end

    always_comb
    begin
        new_len = own_len_reg;
        len_we  = 1'b0;
        if (st_reg == ST_OK && !bad)
        begin
            unique case (op_reg)
                OP_PUSH:
                begin
                    new_len = own_len_reg + CNT_W'(1);
                    len_we  = 1'b1;
                end
                OP_POP:
                begin
                    new_len = own_len_reg - CNT_W'(1);
                    len_we  = 1'b1;
                end
                OP_PEEK, OP_NOP:
                begin
                    new_len = own_len_reg;
                end
                default:
                begin
                    new_len = own_len_reg;
                end
            endcase
        end
        if (bad)
        begin
            new_len = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (cmd.finish && len_we)
        begin
            len_reg[id_reg[LIDX_W-1:0]] <= new_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= op_t'(req_type);
            id_reg      <= stack_id;
            val_reg     <= push_value;
            sidx_reg    <= '0;
            total_reg   <= '0;
            top_end_reg <= '0;
            own_len_reg <= '0;
            rd_reg      <= '0;
        end
        if (cmd.sum_step)
        begin
            total_reg <= sum_next;
            if (ID_W'(sidx_reg) == id_reg)
            begin
                top_end_reg <= sum_next;
                own_len_reg <= len_reg[sidx_reg];
            end
            if (!stat.sum_last)
            begin
                sidx_reg <= sidx_reg + LIDX_W'(1);
            end
        end
        if (cmd.decide)
        begin
            ptr_reg <= total_reg;
            priority if (bad)
            begin
                st_reg <= ST_BADID;
            end
            else if (op_reg == OP_PUSH)
            begin
                st_reg <= full ? ST_FULL : ST_OK;
            end
            else if (op_reg == OP_POP || op_reg == OP_PEEK)
            begin
                st_reg <= empty ? ST_EMPTY : ST_OK;
            end
            else
            begin
                st_reg <= ST_OK;
            end
        end
        if (cmd.top_read)
        begin
            ptr_reg <= top_end_reg;
        end
        if (cmd.top_capture)
        begin
            rd_reg <= rdata_reg;
        end
        if (cmd.up_read)
        begin
            ptr_reg <= ptr_reg - CNT_W'(1);
        end
        if (cmd.down_read)
        begin
            ptr_reg <= ptr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_value_reg   <= rd_reg;
            status_reg       <= st_reg;
            stack_length_reg <= LEN_OUT_W'(new_len);
            stack_empty_reg  <= new_len == '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign status       = status_reg;
    assign stack_length = stack_length_reg;
    assign stack_empty  = stack_empty_reg;

endmodule

[bench/tb_shared_buffer_multi_stack_core.sv]
// Testbench for shared_buffer_multi_stack_core: random and directed requests checked by a predictor.
module tb_shared_buffer_multi_stack_core;
    import sbms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 60;
    localparam int RANDOM_ITEMS   = 1700;

    typedef struct {
        bit                        drain;
        int                        phase;
        op_t                       op;
        logic [ID_W-1:0]           id;
        logic signed [DATA_W-1:0]  value;
    } stack_request_t;

    typedef struct {
        logic signed [DATA_W-1:0]  value;
        status_t                   st;
        logic [LEN_OUT_W-1:0]      len;
        logic                      emp;
    } stack_result_t;

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic [OP_W-1:0]             req_type     = '0;
    logic [ID_W-1:0]             stack_id     = '0;
    logic signed [DATA_W-1:0]    push_value   = '0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic signed [DATA_W-1:0]    read_value;
    logic [ST_W-1:0]             status;
    logic [LEN_OUT_W-1:0]        stack_length;
    logic                        stack_empty;

    stack_request_t              pending_requests[$];
    stack_result_t               results_due[$];
    logic [DATA_W-1:0]           store_copy [CAPACITY];
    int unsigned                 length_copy [NUM_STACKS];
    int                          tx_idle_pct [3] = '{21, 77, 0};
    int                          rx_idle_pct [3] = '{77, 21, 0};
    int                          cur_phase    = 0;
    bit                          req_taken    = 1'b0;
    int                          mismatches   = 0;
    int                          idle_cycles  = 0;

    shared_buffer_multi_stack_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .stack_id     (stack_id),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .stack_length (stack_length),
        .stack_empty  (stack_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic stack_result_t apply_request(op_t op, logic [ID_W-1:0] id,
                                                    logic [DATA_W-1:0] value);
        stack_result_t res;
        int unsigned   total;
        int unsigned   top_end;
        int unsigned   k;
        res.value = '0;
        res.st    = ST_OK;
        res.len   = '0;
        res.emp   = 1'b1;
        if (id >= NUM_STACKS)
        begin
            res.st = ST_BADID;
            return res;
        end
        total   = 0;
        top_end = 0;
        for (k = 0; k < NUM_STACKS; k++)
        begin
            total += length_copy[k];
            if (k <= id)
                top_end += length_copy[k];
        end
        case (op)
            OP_PUSH:
            begin
                if (total >= CAPACITY)
                    res.st = ST_FULL;
                else
                begin
                    for (k = total; k > top_end; k--)
                        store_copy[k] = store_copy[k-1];
                    store_copy[top_end] = value;
                    length_copy[id]++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (length_copy[id] == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.value = store_copy[top_end-1];
                    if (op == OP_POP)
                    begin
                        for (k = top_end - 1; k + 1 < total; k++)
                            store_copy[k] = store_copy[k+1];
                        length_copy[id]--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.len = LEN_OUT_W'(length_copy[id]);
        res.emp = (length_copy[id] == 0);
        return res;
    endfunction

    task automatic add_request(op_t op, int id, logic [DATA_W-1:0] value, int phase);
        stack_request_t r;
        r.drain = 1'b0;
        r.phase = phase;
        r.op    = op;
        r.id    = ID_W'(id);
        r.value = value;
        pending_requests.push_back(r);
    endtask

    task automatic add_drain(int phase);
        stack_request_t r;
        r.drain = 1'b1;
        r.phase = phase;
        r.op    = OP_NOP;
        r.id    = '0;
        r.value = '0;
        pending_requests.push_back(r);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic build_stimulus();
        int  count;
        int  seg_left;
        int  mode;
        int  phase;
        int  roll;
        int  id;
        op_t op;
        add_request(OP_PUSH, 0, 32'h8000_0000, 0);
        add_request(OP_PUSH, 1, 32'h7FFF_FFFF, 0);
        add_request(OP_PUSH, NUM_STACKS - 1, 32'h0000_0000, 0);
        add_request(OP_PUSH, 0, 32'hFFFF_FFFF, 0);
        add_request(OP_PUSH, 1, 32'h0000_0001, 0);
        add_request(OP_PEEK, 0, 32'h1234_5678, 0);
        add_request(OP_PEEK, 1, 32'h0, 0);
        add_request(OP_POP, NUM_STACKS - 1, 32'h0, 0);
        add_request(OP_POP, 0, 32'h0, 0);
        add_request(OP_POP, 0, 32'h0, 0);
        add_request(OP_POP, 0, 32'h0, 0);
        add_request(OP_PEEK, 0, 32'h0, 0);
        add_request(OP_POP, NUM_STACKS - 1, 32'h0, 0);
        add_request(OP_PUSH, 0, 32'h5555_AAAA, 0);
        add_request(OP_POP, 1, 32'h0, 0);
        add_request(OP_PUSH, 3, 32'hDEAD_BEEF, 0);
        add_request(OP_POP, 7, 32'h0, 0);
        add_request(OP_PEEK, 5, 32'h0, 0);
        add_request(OP_NOP, 7, 32'hFFFF_FFFF, 0);
        add_request(OP_NOP, 0, 32'h0, 0);
        add_request(OP_NOP, NUM_STACKS - 1, 32'h0, 0);
        add_drain(0);
        seg_left = 0;
        mode     = 0;
        for (count = 0; count < RANDOM_ITEMS; count++)
        begin
            phase = (count * 3) / RANDOM_ITEMS;
            if (count > 0 && phase != ((count - 1) * 3) / RANDOM_ITEMS)
                add_drain(phase);
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(60, 20);
                mode     = $urandom_range(2);
            end
            seg_left--;
            roll = $urandom_range(99);
            case (mode)
                0:       op = (roll < 80) ? OP_PUSH : (roll < 90) ? OP_POP : OP_PEEK;
                1:       op = (roll < 15) ? OP_PUSH : (roll < 80) ? OP_POP : OP_PEEK;
                default: op = (roll < 40) ? OP_PUSH : (roll < 75) ? OP_POP : OP_PEEK;
            endcase
            if ($urandom_range(99) < 3)
                op = OP_NOP;
            if ($urandom_range(99) < 6)
                id = $urandom_range(7);
            else
                id = $urandom_range(NUM_STACKS - 1);
            add_request(op, id, pick_value(), phase);
        end
    endtask

    always @(negedge clk)
    begin
        stack_request_t nxt;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct[cur_phase]);
            if (!in_valid || req_taken)
            begin
                if (pending_requests.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_requests[0].drain)
                begin
                    in_valid <= 1'b0;
                    if (results_due.size() == 0)
                        void'(pending_requests.pop_front());
                end
                else if ($urandom_range(99) < tx_idle_pct[pending_requests[0].phase])
                    in_valid <= 1'b0;
                else
                begin
                    nxt = pending_requests.pop_front();
                    cur_phase  <= nxt.phase;
                    in_valid   <= 1'b1;
                    req_type   <= nxt.op;
                    stack_id   <= nxt.id;
                    push_value <= nxt.value;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n)
        begin
            req_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (read_value !== want.value)
                    begin
                        $error("read_value: expected %0d, got %0d", want.value, read_value);
                        mismatches++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        mismatches++;
                    end
                    if (stack_length !== want.len)
                    begin
                        $error("stack_length: expected %0d, got %0d", want.len, stack_length);
                        mismatches++;
                    end
                    if (stack_empty !== want.emp)
                    begin
                        $error("stack_empty: expected %0b, got %0b", want.emp, stack_empty);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                results_due.push_back(apply_request(op_t'(req_type), stack_id, push_value));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
